// ----- rtl/iad_pkg.sv -----
// ----------------------------------------------------------------------------
// iad_pkg: shared types and constants for the IMA ADPCM decoder
// Step size table, index adjust table and the decoder state record.
// ----------------------------------------------------------------------------
package iad_pkg;

    localparam int unsigned STEP_LAST  = 88;
    localparam int unsigned INDEX_W    = 7;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned STEP_W     = 15;
    localparam int unsigned CODE_W     = 4;
    localparam int unsigned MOVE_W     = 5;

    // Decoder state carried from one code to the next
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prediction;
        logic        [INDEX_W-1:0]  step_pointer;
    } iad_state_t;

    // Standard 89-entry step size table
    function automatic logic [STEP_W-1:0] step_size(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // Index adjust by code magnitude
    function automatic logic signed [MOVE_W-1:0] index_move(input logic [2:0] mag);
        logic signed [MOVE_W-1:0] m;
        case (mag)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/iad_decode.sv -----
// ----------------------------------------------------------------------------
// iad_decode: one IMA ADPCM decode step
// Combinational: current state and code in, next state out.
// ----------------------------------------------------------------------------
module iad_decode
    import iad_pkg::*;
(
    input  iad_state_t        state_in,
    input  logic [CODE_W-1:0] code,
    input  logic              restart,
    output iad_state_t        state_out
);

    localparam logic signed [17:0] SAT_MIN = -18'sd32768;
    localparam logic signed [17:0] SAT_MAX = 18'sd32767;
    localparam logic signed [7:0]  IDX_MAX = 8'(STEP_LAST);

    iad_state_t                 cur;
    logic [INDEX_W-1:0]         idx;
    logic [STEP_W-1:0]          step;
    logic [16:0]                delta;
    logic signed [17:0]         acc;
    logic signed [7:0]          idx_sum;
    logic signed [SAMPLE_W-1:0] pred_sat;
    logic [INDEX_W-1:0]         pointer_sat;

    // Restart clears state ahead of this code
    always_comb
    begin
        if (restart)
            cur = '0;
        else
            cur = state_in;
    end

    // Step lookup with index clamp
    assign idx  = (cur.step_pointer > INDEX_W'(STEP_LAST)) ? INDEX_W'(STEP_LAST)
                                                           : cur.step_pointer;
    assign step = step_size(idx);

    // Difference from magnitude bits
    always_comb
    begin
        delta = 17'(step >> 3);
        if (code[0])
            delta = delta + 17'(step >> 2);
        if (code[1])
            delta = delta + 17'(step >> 1);
        if (code[2])
            delta = delta + 17'(step);
    end

    // Predictor update with saturation
    always_comb
    begin
        if (code[3])
            acc = 18'(cur.prediction) - $signed({1'b0, delta});
        else
            acc = 18'(cur.prediction) + $signed({1'b0, delta});

        if (acc < SAT_MIN)
            pred_sat = SAMPLE_W'(SAT_MIN);
        else if (acc > SAT_MAX)
            pred_sat = SAMPLE_W'(SAT_MAX);
        else
            pred_sat = acc[SAMPLE_W-1:0];
    end

    // Index adjust and clamp
    assign idx_sum = $signed({1'b0, idx}) + 8'(index_move(code[2:0]));

    always_comb
    begin
        if (idx_sum < 8'sd0)
            pointer_sat = '0;
        else if (idx_sum > IDX_MAX)
            pointer_sat = INDEX_W'(STEP_LAST);
        else
            pointer_sat = idx_sum[INDEX_W-1:0];
    end

    assign state_out = {pred_sat, pointer_sat};

endmodule

// ----- rtl/ima_adpcm_decoder.sv -----
// ----------------------------------------------------------------------------
// ima_adpcm_decoder: streaming IMA ADPCM 4-bit decoder
// One code per request in, one saturated 16-bit sample per request out.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  in      | in_valid / in_ready   | nibble[3:0], restart
//  out     | out_valid / out_ready | sample[15:0], step_position[6:0]
//
//  One request per cycle sustained unless out_ready stalls; out_valid rises when
//  the input register moves on. Input register -> table lookup, add, clamp ->
//  output register; the state register is updated in the same cycle the result
//  is registered. Reset clears state to zero and drops both stages.
//  A stalled output holds; the input stage still fills, then in_ready drops.
// ----------------------------------------------------------------------------
module ima_adpcm_decoder
    import iad_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CODE_W-1:0]          nibble,
    input  logic                       restart,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic [INDEX_W-1:0]         step_position
);

    logic                       in_valid_reg;
    logic [CODE_W-1:0]          nibble_reg;
    logic                       restart_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [INDEX_W-1:0]         position_reg;
    iad_state_t                 state_reg;
    iad_state_t                 state_next;
    logic                       advance;

    // Output stage moves when empty or drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            nibble_reg  <= nibble;
            restart_reg <= restart;
        end
    end

    iad_decode u_decode (
        .state_in  (state_reg),
        .code      (nibble_reg),
        .restart   (restart_reg),
        .state_out (state_next)
    );

    // Decoder state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                state_reg <= state_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            sample_reg   <= state_next.prediction;
            position_reg <= state_next.step_pointer;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign step_position = position_reg;

    // Stored index never leaves the table
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step_pointer <= INDEX_W'(STEP_LAST))
        else $error("step index out of range");

    // Registered result matches the state it left behind
    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=>
            (state_reg.prediction == sample_reg &&
             state_reg.step_pointer == position_reg))
        else $error("result and state disagree");

    // A decoded request always lands in the output stage
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=> out_valid_reg)
        else $error("decoded request lost");

    // Drained with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !in_valid_reg) |=> !out_valid_reg)
        else $error("request repeated");

    // State holds while the output stage stalls
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state moved during stall");

endmodule
